@@ hw/rtl/sha512_pkg.sv @@
package sha512_pkg;

    localparam int WORD_W     = 64;
    localparam int ROUNDS     = 80;
    localparam int BLOCK_WDS  = 16;
    localparam int HASH_WDS   = 8;

    typedef struct packed {
        logic [63:0] msg_word;
        logic [3:0]  valid_bytes;
        logic        final_word;
    } msg_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } digest_item_t;

    localparam logic [2:0] SEL_INPUT  = 3'd0;
    localparam logic [2:0] SEL_PAD    = 3'd1;
    localparam logic [2:0] SEL_ZERO   = 3'd2;
    localparam logic [2:0] SEL_LEN_HI = 3'd3;
    localparam logic [2:0] SEL_LEN_LO = 3'd4;

    typedef struct packed {
        logic       push;
        logic [2:0] sel;
        logic       take;
        logic       init_work;
        logic       round;
        logic [6:0] round_idx;
        logic       fold;
        logic       clear;
        logic [2:0] out_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic final_word;
        logic full_tail;
    } dp_status_t;

    localparam logic [HASH_WDS-1:0][63:0] INIT_HASH = {
        64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
        64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
        64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
        64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
    };

    function automatic logic [63:0] round_const(input logic [6:0] t);
        logic [63:0] k;
        unique case (t)
            7'd0:  k = 64'h428a2f98d728ae22;
            7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;
            7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;
            7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;
            7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;
            7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;
            7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;
            7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;
            7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;
            7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;
            7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;
            7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;
            7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;
            7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;
            7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;
            7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;
            7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;
            7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;
            7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;
            7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;
            7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;
            7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;
            7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;
            7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;
            7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;
            7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;
            7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;
            7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;
            7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;
            7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;
            7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;
            7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;
            7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;
            7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;
            7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;
            7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;
            7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;
            7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;
            7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;
            7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

@@ hw/rtl/sha512_message_hash.sv @@
// Channel  Valid         Stall         Payload
// msg      msg_valid     msg_stall     msg    (msg_item_t: word, valid bytes, final)
// digest   digest_valid  digest_stall  digest (digest_item_t: word, index, last)
//
// One transfer per cycle while a block fills; the 16th word of a block starts
// 80 rounds on the single round unit and then a fold into the chain. The
// final word adds padding words at one per cycle, one or two compressions,
// then eight digest transfers. msg_stall is high through each compression,
// the padding words and the digest transfers; a stalled digest holds. Reset
// loads the initial hash and clears all counts.
module sha512_message_hash
    import sha512_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    output logic         msg_stall,
    input  msg_item_t    msg,
    output logic         digest_valid,
    input  logic         digest_stall,
    output digest_item_t digest
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sha512_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .status       (status),
        .cmd          (cmd)
    );

    sha512_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .cmd    (cmd),
        .status (status),
        .digest (digest)
    );

endmodule

@@ hw/rtl/sha512_dp.sv @@
module sha512_dp
    import sha512_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  msg_item_t    msg,
    input  dp_cmd_t      cmd,
    output dp_status_t   status,
    output digest_item_t digest
);

    logic [63:0] chain_reg [HASH_WDS];
    logic [63:0] work_reg  [HASH_WDS];
    logic [63:0] sched_reg [BLOCK_WDS];
    logic [63:0] msg_bytes_reg;
    logic [63:0] msg_bytes_next;

    logic [3:0]  nb_eff;
    logic [3:0]  nb_add;
    logic [63:0] tail_word;
    logic [63:0] push_word;
    logic [63:0] sched_new;
    logic [63:0] t1;
    logic [63:0] t2;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    always_comb
    begin
        nb_eff = (msg.valid_bytes > 4'd8) ? 4'd8 : msg.valid_bytes;
        nb_add = msg.final_word ? nb_eff : 4'd8;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < nb_eff)
                tail_word[63-8*i -: 8] = msg.msg_word[63-8*i -: 8];
            else if (4'(i) == nb_eff)
                tail_word[63-8*i -: 8] = 8'h80;
            else
                tail_word[63-8*i -: 8] = 8'h00;
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            SEL_INPUT:  push_word = msg.final_word ? tail_word : msg.msg_word;
            SEL_PAD:    push_word = 64'h8000000000000000;
            SEL_ZERO:   push_word = '0;
            SEL_LEN_HI: push_word = {61'd0, msg_bytes_reg[63:61]};
            SEL_LEN_LO: push_word = {msg_bytes_reg[60:0], 3'd0};
            default:    push_word = '0;
        endcase
    end

    assign sched_new = (rotr(sched_reg[14], 19) ^ rotr(sched_reg[14], 61) ^ (sched_reg[14] >> 6))
                     + sched_reg[9]
                     + (rotr(sched_reg[1], 1) ^ rotr(sched_reg[1], 8) ^ (sched_reg[1] >> 7))
                     + sched_reg[0];

    assign t1 = work_reg[7]
              + (rotr(work_reg[4], 14) ^ rotr(work_reg[4], 18) ^ rotr(work_reg[4], 41))
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + round_const(cmd.round_idx) + sched_reg[0];
    assign t2 = (rotr(work_reg[0], 28) ^ rotr(work_reg[0], 34) ^ rotr(work_reg[0], 39))
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round)
        begin
            for (int i = 0; i < BLOCK_WDS - 1; i++)
                sched_reg[i] <= sched_reg[i+1];
            sched_reg[BLOCK_WDS-1] <= cmd.push ? push_word : sched_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_work)
        begin
            for (int i = 0; i < HASH_WDS; i++)
                work_reg[i] <= chain_reg[i];
        end
        else if (cmd.round)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    always_comb
    begin
        if (cmd.clear)
            msg_bytes_next = '0;
        else if (cmd.take)
            msg_bytes_next = msg_bytes_reg + {60'd0, nb_add};
        else
            msg_bytes_next = msg_bytes_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_bytes_reg <= '0;
            for (int i = 0; i < HASH_WDS; i++)
                chain_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            msg_bytes_reg <= msg_bytes_next;
            if (cmd.clear)
            begin
                for (int i = 0; i < HASH_WDS; i++)
                    chain_reg[i] <= INIT_HASH[i];
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < HASH_WDS; i++)
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
    end

    assign status.final_word = msg.final_word;
    assign status.full_tail  = (nb_eff == 4'd8);

    assign digest.digest_word = chain_reg[cmd.out_idx];
    assign digest.word_index  = cmd.out_idx;
    assign digest.digest_last = &cmd.out_idx;

endmodule

@@ hw/rtl/sha512_ctrl.sv @@
module sha512_ctrl
    import sha512_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    output logic       msg_stall,
    output logic       digest_valid,
    input  logic       digest_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [3:0] LAST_WORD  = 4'(BLOCK_WDS - 1);
    localparam logic [3:0] LEN_WORD   = 4'(BLOCK_WDS - 2);

    logic [2:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] oidx_reg, oidx_next;
    logic       padding_reg, padding_next;
    logic       pad8_reg, pad8_next;
    logic       lenhi_reg, lenhi_next;
    logic       last_reg, last_next;

    assign msg_stall    = (state_reg != S_IDLE);
    assign digest_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        round_next    = round_reg;
        oidx_next     = oidx_reg;
        padding_next  = padding_reg;
        pad8_next     = pad8_reg;
        lenhi_next    = lenhi_reg;
        last_next     = last_reg;
        cmd           = '0;
        cmd.sel       = SEL_ZERO;
        cmd.round_idx = round_reg;
        cmd.out_idx   = oidx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    cmd.push = 1'b1;
                    cmd.take = 1'b1;
                    cmd.sel  = SEL_INPUT;
                    cnt_next = cnt_reg + 4'd1;
                    if (status.final_word)
                    begin
                        padding_next = 1'b1;
                        pad8_next    = status.full_tail;
                    end
                    if (cnt_reg == LAST_WORD)
                    begin
                        cmd.init_work = 1'b1;
                        round_next    = '0;
                        state_next    = S_ROUND;
                    end
                    else if (status.final_word)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                cmd.push = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                priority if (pad8_reg)
                begin
                    cmd.sel   = SEL_PAD;
                    pad8_next = 1'b0;
                end
                else if (cnt_reg == LEN_WORD)
                begin
                    cmd.sel    = SEL_LEN_HI;
                    lenhi_next = 1'b1;
                end
                else if (cnt_reg == LAST_WORD && lenhi_reg)
                begin
                    cmd.sel    = SEL_LEN_LO;
                    lenhi_next = 1'b0;
                    last_next  = 1'b1;
                end
                else
                    cmd.sel = SEL_ZERO;
                if (cnt_reg == LAST_WORD)
                begin
                    cmd.init_work = 1'b1;
                    round_next    = '0;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                priority if (last_reg)
                begin
                    oidx_next  = '0;
                    state_next = S_OUT;
                end
                else if (padding_reg)
                    state_next = S_PAD;
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (!digest_stall)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (&oidx_reg)
                    begin
                        cmd.clear    = 1'b1;
                        padding_next = 1'b0;
                        last_next    = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            round_reg   <= '0;
            oidx_reg    <= '0;
            padding_reg <= 1'b0;
            pad8_reg    <= 1'b0;
            lenhi_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            round_reg   <= round_next;
            oidx_reg    <= oidx_next;
            padding_reg <= padding_next;
            pad8_reg    <= pad8_next;
            lenhi_reg   <= lenhi_next;
            last_reg    <= last_next;
        end
    end

endmodule

@@ bench/sha512_digest_check.sv @@
module sha512_digest_check
    import sha512_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    input  logic         msg_stall,
    input  msg_item_t    msg,
    input  logic         digest_valid,
    input  logic         digest_stall,
    input  digest_item_t digest,
    output int           errors,
    output int           pending
);

    logic [63:0]  round_k [80];
    logic [63:0]  hash_iv [8];
    logic [63:0]  chain [8];
    logic [63:0]  sched [16];
    int           fill;
    logic [63:0]  total_bytes;
    digest_item_t expected_digest [$];

    initial
    begin
        round_k = '{
            64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
            64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
            64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
            64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
            64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
            64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
            64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
            64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
            64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
            64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
            64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
            64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
            64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
            64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
            64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
            64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
            64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
            64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
            64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
            64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
            64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
            64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
            64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
            64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
            64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
        };
        hash_iv = '{
            64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
            64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
            64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
        };
    end

    function automatic logic [63:0] rotr(input logic [63:0] v, input int c);
        return (v >> c) | (v << (64 - c));
    endfunction

    task automatic restart_message();
        for (int j = 0; j < 8; j++)
        begin
            chain[j] = hash_iv[j];
        end
        for (int j = 0; j < 16; j++)
        begin
            sched[j] = '0;
        end
        fill        = 0;
        total_bytes = '0;
    endtask

    task automatic compress_block();
        logic [63:0] v [8];
        logic [63:0] a, b, s0, s1, w, t1, t2;
        for (int j = 0; j < 8; j++)
        begin
            v[j] = chain[j];
        end
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                a  = sched[(t - 2) & 15];
                b  = sched[(t - 15) & 15];
                s1 = rotr(a, 19) ^ rotr(a, 61) ^ (a >> 6);
                s0 = rotr(b, 1) ^ rotr(b, 8) ^ (b >> 7);
                sched[t & 15] = sched[t & 15] + s1 + sched[(t - 7) & 15] + s0;
            end
            w  = sched[t & 15];
            t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k[t] + w;
            t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
        begin
            chain[j] = chain[j] + v[j];
        end
    endtask

    task automatic absorb_word(input logic [63:0] w);
        sched[fill] = w;
        fill++;
        if (fill == 16)
        begin
            compress_block();
            fill = 0;
        end
    endtask

    task automatic hash_word(input msg_item_t item);
        int           nb;
        logic [63:0]  keep;
        digest_item_t d;
        if (!item.final_word)
        begin
            total_bytes = total_bytes + 64'd8;
            absorb_word(item.msg_word);
            return;
        end
        nb = (item.valid_bytes > 4'd8) ? 8 : int'(item.valid_bytes);
        total_bytes = total_bytes + 64'(nb);
        if (nb == 8)
        begin
            absorb_word(item.msg_word);
            absorb_word(64'h8000_0000_0000_0000);
        end
        else
        begin
            keep = (nb == 0) ? 64'd0 : (~64'd0 << (64 - 8 * nb));
            absorb_word((item.msg_word & keep) | (64'h80 << (56 - 8 * nb)));
        end
        while (fill != 14)
        begin
            absorb_word('0);
        end
        absorb_word(total_bytes >> 61);
        absorb_word(total_bytes << 3);
        for (int k = 0; k < 8; k++)
        begin
            d.digest_word = chain[k];
            d.word_index  = 3'(k);
            d.digest_last = (k == 7);
            expected_digest.push_back(d);
        end
        restart_message();
    endtask

    task automatic report(input string what);
        $display("%0t digest check: %s", $time, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_item_t want;
        if (!rst_n)
        begin
            restart_message();
            expected_digest.delete();
        end
        else
        begin
            if (digest_valid && !digest_stall)
            begin
                if (expected_digest.size() == 0)
                begin
                    report($sformatf("unexpected transfer word %h index %0d",
                                     digest.digest_word, digest.word_index));
                end
                else
                begin
                    want = expected_digest.pop_front();
                    if (digest.digest_word !== want.digest_word)
                    begin
                        report($sformatf("digest_word got %h want %h (index %0d)",
                                         digest.digest_word, want.digest_word,
                                         want.word_index));
                    end
                    if (digest.word_index !== want.word_index)
                    begin
                        report($sformatf("word_index got %0d want %0d",
                                         digest.word_index, want.word_index));
                    end
                    if (digest.digest_last !== want.digest_last)
                    begin
                        report($sformatf("digest_last got %b want %b (index %0d)",
                                         digest.digest_last, want.digest_last,
                                         want.word_index));
                    end
                end
            end
            if (msg_valid && !msg_stall)
            begin
                hash_word(msg);
            end
        end
        pending = expected_digest.size();
    end

endmodule

@@ bench/tb.sv @@
module tb;
    import sha512_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 200;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         msg_valid    = 1'b0;
    msg_item_t    msg          = '0;
    logic         digest_stall = 1'b0;
    logic         msg_stall;
    logic         digest_valid;
    digest_item_t digest;

    int errors;
    int pending;
    int quiet      = 0;
    int sent_items = 0;
    int stall_run  = 0;
    int open_run   = 0;
    bit burst      = 1'b0;

    sha512_message_hash DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    sha512_digest_check check (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // hold each payload until its transfer, then return at the next falling edge
    task automatic send_item(input logic [63:0] w, input logic [3:0] nb, input logic fin);
        int gap;
        gap = burst ? 0 : idle_len();
        repeat (gap)
        begin
            msg_valid <= 1'b0;
            @(negedge clk);
        end
        msg_valid <= 1'b1;
        msg       <= {w, nb, fin};
        do
            @(posedge clk);
        while (msg_stall);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_message(input int nwords, input logic [3:0] last_nb);
        for (int i = 0; i < nwords - 1; i++)
        begin
            send_item(pick_word(), 4'($urandom_range(0, 15)), 1'b0);
        end
        send_item(pick_word(), last_nb, 1'b1);
    endtask

    always @(negedge clk)
    begin
        if (stall_run > 0)
        begin
            digest_stall <= 1'b1;
            stall_run--;
        end
        else if (open_run > 0)
        begin
            digest_stall <= 1'b0;
            open_run--;
        end
        else
        begin
            digest_stall <= 1'b0;
            stall_run = idle_len();
            open_run  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 6);
        end
    end

    always @(posedge clk)
    begin
        if ((msg_valid && !msg_stall) || (digest_valid && !digest_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int          n;
        int          r;
        logic [3:0]  nb;
        int          directed_items;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty message, with junk in the invalid bytes
        send_item('1, 4'd0, 1'b1);
        send_item('1, 4'd8, 1'b1);
        // count above eight
        send_item('0, 4'd15, 1'b1);
        send_item('1, 4'd3, 1'b1);
        send_item('1, 4'd0, 1'b0);
        send_item({$urandom, $urandom}, 4'd1, 1'b1);
        // 112-byte tail forces an extra padding block
        burst = 1'b1;
        send_message(14, 4'd8);
        burst = 1'b0;
        directed_items = sent_items;

        while (sent_items < directed_items + RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 15)
                n = 1;
            else if (r < 60)
                n = $urandom_range(1, 8);
            else if (r < 85)
                n = $urandom_range(13, 17);
            else
                n = $urandom_range(9, 32);
            nb = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 8))
                                            : 4'($urandom_range(0, 15));
            send_message(n, nb);
        end
        msg_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
